// ----- rtl/core/grid_cell_range_binner_core_macros.svh -----
// assertion helpers for the grid binner core
`ifndef GRID_CELL_RANGE_BINNER_CORE_MACROS_SVH
`define GRID_CELL_RANGE_BINNER_CORE_MACROS_SVH

// same-cycle implication
`define GCRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GCRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/gcrb_pkg.sv -----
`default_nettype none
package gcrb_pkg;

  localparam int COORD_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIM_W      = 4;
  localparam int SIZE_W     = 23;
  localparam int POS_W      = 3;
  localparam int INDEX_W    = 6;
  localparam int QUOT_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS   = 3'd0,
    REG_GRID_ROWS   = 3'd1,
    REG_CELL_WIDTH  = 3'd2,
    REG_CELL_HEIGHT = 3'd3,
    REG_CAMERA_X    = 3'd4,
    REG_CAMERA_Y    = 3'd5
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- rtl/core/gcrb_if.sv -----
`default_nettype none
interface gcrb_rect_if;
  import gcrb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic signed [COORD_W-1:0] rect_right;
  logic signed [COORD_W-1:0] rect_bottom;
  logic                      is_ui;
  modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, is_ui,
                  input ready);
  modport sink (input valid, rect_left, rect_top, rect_right, rect_bottom, is_ui,
                output ready);
endinterface

interface gcrb_cell_if;
  import gcrb_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] cell_index;
  logic [POS_W-1:0]   cell_col;
  logic [POS_W-1:0]   cell_row;
  logic               last;
  modport source (output valid, cell_index, cell_col, cell_row, last, input ready);
  modport sink (input valid, cell_index, cell_col, cell_row, last, output ready);
endinterface

interface gcrb_cfg_if;
  import gcrb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/grid_cell_range_binner_core.sv -----
// output: after a request is binned, one cell per cycle while the cell side is ready
// binning: per edge a camera add for UI requests, a magnitude step and 4 compare-subtract steps
//   on the shared subtractor, for each edge in turn, then a setup step and an output register
// no new rectangle is accepted until the previous one has issued its last cell or proved empty
// reset: synchronous, restores grid 1x1, cell 32.0 x 32.0, camera at zero
`default_nettype none
`include "grid_cell_range_binner_core_macros.svh"
module grid_cell_range_binner_core #(
  parameter int MAX_COLS   = 8,
  parameter int MAX_ROWS   = 8,
  parameter int COORD_BITS = 24
) (
  input  wire         clk,
  input  wire         rst,
  gcrb_rect_if.sink   rect,
  gcrb_cell_if.source cells,
  gcrb_cfg_if.sink    cfg
);
  import gcrb_pkg::*;

  localparam int WW = (COORD_BITS > COORD_W + 1) ? COORD_BITS : COORD_W + 1;
  localparam int DW = ((WW > SIZE_W + 3) ? WW : SIZE_W + 3) + 1;
  localparam logic signed [WW-1:0] SAT_HI =
    {{(WW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_ABS, S_DIV, S_SETUP, S_EMIT} state_t;

  state_t state;

  logic [DIM_W-1:0]          grid_cols, grid_rows;
  logic [SIZE_W-1:0]         cell_width, cell_height;
  logic signed [COORD_W-1:0] camera_x, camera_y;

  logic signed [COORD_W-1:0] edge_l, edge_t, edge_r, edge_b;
  logic                      ui;
  logic [1:0]                edge_sel;
  logic signed [WW-1:0]      val;
  logic                      neg;
  logic [WW-1:0]             rem;
  logic [1:0]                k;
  logic [QUOT_W-1:0]         qbits;
  logic [QUOT_W-1:0]         sx, sy;
  logic [POS_W-1:0]          ex, ey;
  logic                      end_neg;
  logic [POS_W-1:0]          col, row;
  logic [INDEX_W-1:0]        row_base;

  logic               out_valid;
  logic [INDEX_W-1:0] out_index;
  logic [POS_W-1:0]   out_col, out_row;
  logic               out_last;

  logic [DIM_W-1:0]          cols_eff, rows_eff, dim;
  logic [SIZE_W-1:0]         cw_eff, ch_eff, dv;
  logic signed [COORD_W-1:0] cur_e, cam;
  logic signed [WW-1:0]      sum_w, sat_w;
  logic [DW-1:0]             trial;
  logic [QUOT_W-1:0]         qbits_next, qsat;
  logic [POS_W-1:0]          e_clamp;
  logic                      empty;
  logic                      at_last;
  logic [INDEX_W-1:0]        chk_idx;

  always_comb begin
    if (grid_cols == '0) cols_eff = DIM_W'(1);
    else if (grid_cols > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
    else cols_eff = grid_cols;
    if (grid_rows == '0) rows_eff = DIM_W'(1);
    else if (grid_rows > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
    else rows_eff = grid_rows;
    cw_eff = (cell_width == '0) ? SIZE_W'(1) : cell_width;
    ch_eff = (cell_height == '0) ? SIZE_W'(1) : cell_height;
    dv  = edge_sel[0] ? ch_eff : cw_eff;
    dim = edge_sel[0] ? rows_eff : cols_eff;
    unique case (edge_sel)
      2'd0: cur_e = edge_l;
      2'd1: cur_e = edge_t;
      2'd2: cur_e = edge_r;
      default: cur_e = edge_b;
    endcase
    cam   = edge_sel[0] ? camera_y : camera_x;
    sum_w = WW'(cur_e) + WW'(cam);
    if (sum_w > SAT_HI) sat_w = SAT_HI;
    else if (sum_w < SAT_LO) sat_w = SAT_LO;
    else sat_w = sum_w;
    // shared compare-subtract unit
    trial = {{(DW - WW){1'b0}}, rem} - (DW'(dv) << k);
    qbits_next = qbits;
    if (!trial[DW-1]) qbits_next[k] = 1'b1;
    qsat = qbits_next[QUOT_W-1] ? QUOT_W'(8) : {1'b0, qbits_next[QUOT_W-2:0]};
    e_clamp = (qsat >= dim) ? POS_W'(dim - DIM_W'(1)) : qsat[POS_W-1:0];
    empty = end_neg || (sx > {1'b0, ex}) || (sy > {1'b0, ey});
    at_last = (col == ex) && (row == ey);
    chk_idx = {3'b0, cells.cell_row} * {2'b0, cols_eff} + {3'b0, cells.cell_col};
  end

  assign rect.ready       = (state == S_IDLE) && !rst;
  assign cfg.ready        = !rst;
  assign cells.valid      = out_valid;
  assign cells.cell_index = out_index;
  assign cells.cell_col   = out_col;
  assign cells.cell_row   = out_row;
  assign cells.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols   <= DIM_W'(1);
      grid_rows   <= DIM_W'(1);
      cell_width  <= SIZE_W'(512);
      cell_height <= SIZE_W'(512);
      camera_x    <= '0;
      camera_y    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_GRID_COLS:   grid_cols   <= cfg.data[DIM_W-1:0];
        REG_GRID_ROWS:   grid_rows   <= cfg.data[DIM_W-1:0];
        REG_CELL_WIDTH:  cell_width  <= cfg.data[SIZE_W-1:0];
        REG_CELL_HEIGHT: cell_height <= cfg.data[SIZE_W-1:0];
        REG_CAMERA_X:    camera_x    <= signed'(cfg.data[COORD_W-1:0]);
        REG_CAMERA_Y:    camera_y    <= signed'(cfg.data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      edge_sel  <= '0;
      k         <= '0;
      end_neg   <= 1'b0;
    end else begin
      if (cells.ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (rect.valid) begin
            edge_l   <= rect.rect_left;
            edge_t   <= rect.rect_top;
            edge_r   <= rect.rect_right;
            edge_b   <= rect.rect_bottom;
            ui       <= rect.is_ui;
            edge_sel <= '0;
            end_neg  <= 1'b0;
            state    <= S_PREP;
          end
        end
        S_PREP: begin
          val   <= ui ? sat_w : WW'(cur_e);
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= val[WW-1];
          rem   <= val[WW-1] ? WW'(-val) : WW'(val);
          qbits <= '0;
          k     <= 2'd3;
          state <= S_DIV;
        end
        S_DIV: begin
          qbits <= qbits_next;
          if (!trial[DW-1]) rem <= trial[WW-1:0];
          k <= k - 2'd1;
          if (k == 2'd0) begin
            if (!edge_sel[1]) begin
              // start edge, clamp at zero
              if (edge_sel[0]) sy <= neg ? '0 : qsat;
              else sx <= neg ? '0 : qsat;
            end else begin
              // end edge, clamp at grid size less one
              if (neg && qsat != '0) end_neg <= 1'b1;
              if (edge_sel[0]) ey <= neg ? '0 : e_clamp;
              else ex <= neg ? '0 : e_clamp;
            end
            edge_sel <= edge_sel + 2'd1;
            state    <= (edge_sel == 2'd3) ? S_SETUP : S_PREP;
          end
        end
        S_SETUP: begin
          if (empty) begin
            state <= S_IDLE;
          end else begin
            col      <= sx[POS_W-1:0];
            row      <= sy[POS_W-1:0];
            row_base <= {3'b0, sy[POS_W-1:0]} * {2'b0, cols_eff};
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || cells.ready) begin
            out_valid <= 1'b1;
            out_index <= row_base + {3'b0, col};
            out_col   <= col;
            out_row   <= row;
            out_last  <= at_last;
            if (at_last) begin
              state <= S_IDLE;
            end else if (col == ex) begin
              col      <= sx[POS_W-1:0];
              row      <= row + POS_W'(1);
              row_base <= row_base + {2'b0, cols_eff};
            end else begin
              col <= col + POS_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GCRB_ASSERT_IMP(a_index_row_major, cells.valid, cells.cell_index == chk_idx, "index mismatch")
  `GCRB_ASSERT_NXT(a_busy_after_request, rect.valid && rect.ready, !rect.ready, "ready after request")
  `GCRB_ASSERT_IMP(a_emit_in_range, state == S_EMIT, col <= ex && row <= ey, "cell outside range")

endmodule
`default_nettype wire

// ----- verif/grid_cell_range_binner_core_tb.sv -----
module grid_cell_range_binner_core_tb;
  import gcrb_pkg::*;

  localparam int     GRID_MAX_COLS = 8;
  localparam int     GRID_MAX_ROWS = 8;
  localparam longint COORD_MAX     = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN     = -COORD_MAX - 1;
  localparam int     SETTLE_CYCLES = 80;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     NUM_PHASES    = 8;
  localparam int     PHASE_ITEMS   = 19;
  localparam int     NUM_DIRECTED  = 39;

  // register slots past the last defined register, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic                      ui;
  } rect_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               last;
  } cell_t;

  typedef enum logic {ROW_RECT, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ONE} row_outcome_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    rect_t                 rect;
    row_outcome_e          outcome;
    cell_t                 one_cell;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  gcrb_rect_if rect_bus ();
  gcrb_cell_if cell_bus ();
  gcrb_cfg_if  cfg_bus ();

  grid_cell_range_binner_core #(
    .MAX_COLS  (GRID_MAX_COLS),
    .MAX_ROWS  (GRID_MAX_ROWS),
    .COORD_BITS(COORD_W)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .rect (rect_bus),
    .cells(cell_bus),
    .cfg  (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copy, follows every accepted write
  logic [DIM_W-1:0]          cur_cols   = 4'd1;
  logic [DIM_W-1:0]          cur_rows   = 4'd1;
  logic [SIZE_W-1:0]         cur_cell_w = 23'd512;
  logic [SIZE_W-1:0]         cur_cell_h = 23'd512;
  logic signed [COORD_W-1:0] cur_cam_x  = '0;
  logic signed [COORD_W-1:0] cur_cam_y  = '0;

  cell_t pending_cells [$];
  int    cell_errors = 0;
  bit    quiet       = 1'b0;
  bit    hold_go     = 1'b0;

  function automatic longint sat_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint eff_dim(input logic [DIM_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return longint'(v);
  endfunction

  function automatic longint eff_size(input logic [SIZE_W-1:0] v);
    return (v == 0) ? 1 : longint'(v);
  endfunction

  // covered cells of one rectangle, row-major, appended to pending_cells
  function automatic void bin_rect_cells(input rect_t rq);
    longint l, t, r, b, cw, ch, cols, rows, sx, ex, sy, ey, x, y;
    cell_t  c;
    l = longint'($signed(rq.left));
    t = longint'($signed(rq.top));
    r = longint'($signed(rq.right));
    b = longint'($signed(rq.bottom));
    if (rq.ui) begin
      l = sat_coord(l + longint'(cur_cam_x));
      r = sat_coord(r + longint'(cur_cam_x));
      t = sat_coord(t + longint'(cur_cam_y));
      b = sat_coord(b + longint'(cur_cam_y));
    end
    cw   = eff_size(cur_cell_w);
    ch   = eff_size(cur_cell_h);
    cols = eff_dim(cur_cols, GRID_MAX_COLS);
    rows = eff_dim(cur_rows, GRID_MAX_ROWS);
    sx = l / cw;
    ex = r / cw;
    sy = t / ch;
    ey = b / ch;
    if (sx < 0) sx = 0;
    if (sy < 0) sy = 0;
    if (ex >= cols) ex = cols - 1;
    if (ey >= rows) ey = rows - 1;
    if (sx > ex || sy > ey) return;
    for (y = sy; y <= ey; y++) begin
      for (x = sx; x <= ex; x++) begin
        c.idx  = INDEX_W'(y * cols + x);
        c.col  = POS_W'(x);
        c.row  = POS_W'(y);
        c.last = (y == ey && x == ex);
        pending_cells.push_back(c);
      end
    end
  endfunction

  function automatic row_t rect_row(input longint l, input longint t, input longint r,
                                    input longint b, input bit ui, input row_outcome_e oc,
                                    input int ci = 0, input int cc = 0, input int cr = 0);
    row_t x;
    x                 = '0;
    x.kind            = ROW_RECT;
    x.reg_idx         = REG_GRID_COLS;
    x.rect.left       = COORD_W'(l);
    x.rect.top        = COORD_W'(t);
    x.rect.right      = COORD_W'(r);
    x.rect.bottom     = COORD_W'(b);
    x.rect.ui         = ui;
    x.outcome         = oc;
    x.one_cell.idx    = INDEX_W'(ci);
    x.one_cell.col    = POS_W'(cc);
    x.one_cell.row    = POS_W'(cr);
    x.one_cell.last   = 1'b1;
    return x;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t x;
    x          = '0;
    x.kind     = ROW_REG;
    x.reg_idx  = idx;
    x.reg_data = data;
    x.outcome  = EXP_NONE;
    return x;
  endfunction

  row_t dir_tab [NUM_DIRECTED] = '{
    // reset grid: one cell of 32.0
    rect_row(0, 0, 0, 0, 0, EXP_ONE, 0, 0, 0),
    rect_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, EXP_ONE, 0, 0, 0),
    rect_row(512, 0, 1000, 0, 0, EXP_NONE),
    rect_row(0, 0, -512, 0, 0, EXP_NONE),
    rect_row(0, -600, 0, -513, 0, EXP_NONE),
    rect_row(0, 0, 511, 511, 1, EXP_ONE, 0, 0, 0),
    // largest grid, smallest cells
    reg_row(REG_GRID_COLS, 24'd8),
    reg_row(REG_GRID_ROWS, 24'd8),
    reg_row(REG_CELL_WIDTH, 24'd1),
    reg_row(REG_CELL_HEIGHT, 24'd1),
    rect_row(0, 0, 7, 7, 0, EXP_PREDICT),
    rect_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, EXP_PREDICT),
    rect_row(7, 7, 7, 7, 0, EXP_ONE, 63, 7, 7),
    rect_row(3, 2, 1, 5, 0, EXP_NONE),
    // negative edges truncate toward zero
    reg_row(REG_CELL_WIDTH, 24'd16),
    reg_row(REG_CELL_HEIGHT, 24'd16),
    rect_row(-15, -15, -15, -15, 0, EXP_ONE, 0, 0, 0),
    rect_row(-16, 0, 20, 40, 0, EXP_PREDICT),
    // zero and oversize grid, zero and largest cell size
    reg_row(REG_GRID_COLS, 24'hFFFFF0),
    reg_row(REG_GRID_ROWS, 24'd15),
    reg_row(REG_CELL_WIDTH, 24'h800000),
    reg_row(REG_CELL_HEIGHT, 24'h7FFFFF),
    rect_row(3, -5, 100, COORD_MAX, 0, EXP_PREDICT),
    rect_row(0, COORD_MAX, 0, COORD_MAX, 0, EXP_ONE, 1, 0, 1),
    // camera at the extremes, saturating sums
    reg_row(REG_GRID_COLS, 24'd8),
    reg_row(REG_GRID_ROWS, 24'd8),
    reg_row(REG_CELL_WIDTH, 24'd16),
    reg_row(REG_CELL_HEIGHT, 24'd16),
    reg_row(REG_CAMERA_X, 24'h7FFFFF),
    reg_row(REG_CAMERA_Y, 24'h800000),
    rect_row(COORD_MAX - 15, 0, COORD_MAX, 100, 1, EXP_NONE),
    rect_row(COORD_MIN, COORD_MAX, 40, COORD_MAX, 1, EXP_PREDICT),
    rect_row(COORD_MIN, COORD_MAX, 40, COORD_MAX, 0, EXP_PREDICT),
    reg_row(REG_CAMERA_X, 24'h800000),
    reg_row(REG_CAMERA_Y, 24'h7FFFFF),
    rect_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1, EXP_PREDICT),
    reg_row(REG_UNUSED_LO, 24'hFFFFFF),
    reg_row(REG_UNUSED_HI, 24'hFFFFFF),
    rect_row(0, 0, 31, 31, 0, EXP_PREDICT)
  };

  function automatic longint span_pick(input longint lo, input longint hi);
    if (hi <= lo) return lo;
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned      m;
    logic [DIM_W-1:0] v;
    logic [19:0]      hi;
    m = $urandom_range(9);
    if (m < 7) v = DIM_W'($urandom_range(8, 1));
    else if (m == 7) v = '0;
    else v = DIM_W'($urandom_range(15, 9));
    hi = $urandom_range(1) ? 20'($urandom()) : 20'd0;
    return {hi, v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int unsigned       m;
    logic [SIZE_W-1:0] v;
    m = $urandom_range(9);
    if (m == 0) v = '0;
    else if (m == 1) v = '1;
    else if (m < 6) v = SIZE_W'($urandom_range(64, 1));
    else if (m < 9) v = SIZE_W'($urandom_range(8192, 65));
    else v = SIZE_W'($urandom());
    return {1'($urandom_range(1)), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_camera();
    int unsigned m;
    m = $urandom_range(9);
    if (m < 6) return CFG_DATA_W'(int'($urandom_range(4096)) - 2048);
    if (m == 6) return 24'h7FFFFF;
    if (m == 7) return 24'h800000;
    return CFG_DATA_W'($urandom());
  endfunction

  // mostly rectangles around the grid under the current setting, some pure noise
  function automatic rect_t make_rect();
    longint cw, ch, spx, spy, l, t, r, b;
    rect_t  rq;
    if ($urandom_range(99) < 20) begin
      rq = {COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
            COORD_W'($urandom()), 1'($urandom_range(1))};
      return rq;
    end
    cw  = eff_size(cur_cell_w);
    ch  = eff_size(cur_cell_h);
    spx = cw * eff_dim(cur_cols, GRID_MAX_COLS);
    spy = ch * eff_dim(cur_rows, GRID_MAX_ROWS);
    l = span_pick(-cw, spx);
    r = l + span_pick(-cw / 2, spx / 2 + cw);
    t = span_pick(-ch, spy);
    b = t + span_pick(-ch / 2, spy / 2 + ch);
    rq.ui = 1'($urandom_range(1));
    if (rq.ui) begin
      l = l - longint'(cur_cam_x);
      r = r - longint'(cur_cam_x);
      t = t - longint'(cur_cam_y);
      b = b - longint'(cur_cam_y);
    end
    rq.left   = COORD_W'(sat_coord(l));
    rq.right  = COORD_W'(sat_coord(r));
    rq.top    = COORD_W'(sat_coord(t));
    rq.bottom = COORD_W'(sat_coord(b));
    return rq;
  endfunction

  task automatic send_rect(input rect_t rq, input row_outcome_e oc, input cell_t one);
    while (!quiet && $urandom_range(99) < 16) begin
      rect_bus.valid <= 1'b0;
      @(posedge clk);
    end
    rect_bus.valid       <= 1'b1;
    rect_bus.rect_left   <= rq.left;
    rect_bus.rect_top    <= rq.top;
    rect_bus.rect_right  <= rq.right;
    rect_bus.rect_bottom <= rq.bottom;
    rect_bus.is_ui       <= rq.ui;
    @(posedge clk);
    while (!rect_bus.ready) @(posedge clk);
    case (oc)
      EXP_PREDICT: bin_rect_cells(rq);
      EXP_ONE:     pending_cells.push_back(one);
      default:     ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_GRID_COLS:   cur_cols   = data[DIM_W-1:0];
      REG_GRID_ROWS:   cur_rows   = data[DIM_W-1:0];
      REG_CELL_WIDTH:  cur_cell_w = data[SIZE_W-1:0];
      REG_CELL_HEIGHT: cur_cell_h = data[SIZE_W-1:0];
      REG_CAMERA_X:    cur_cam_x  = data[COORD_W-1:0];
      REG_CAMERA_Y:    cur_cam_y  = data[COORD_W-1:0];
      default:         ;
    endcase
    @(posedge clk);
  endtask

  // wait for every expected cell, then let a request with no cells finish
  task automatic settle_cells();
    rect_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_cell(input string what, input cell_t want);
    if (cell_errors < 10)
      $display("%s: expected idx %0d col %0d row %0d last %0b, got idx %0d col %0d row %0d last %0b",
               what, want.idx, want.col, want.row, want.last, cell_bus.cell_index,
               cell_bus.cell_col, cell_bus.cell_row, cell_bus.last);
    cell_errors++;
  endtask

  always @(posedge clk) begin : cell_check
    cell_t want;
    if (!rst && cell_bus.valid && cell_bus.ready) begin
      if (pending_cells.size() == 0) begin
        flag_cell("unexpected cell", '0);
      end else begin
        want = pending_cells.pop_front();
        if (cell_bus.cell_index !== want.idx || cell_bus.cell_col !== want.col ||
            cell_bus.cell_row !== want.row || cell_bus.last !== want.last)
          flag_cell("cell mismatch", want);
      end
    end
  end

  // cell side ready, random unless quiet, with one long hold-off
  initial begin : cell_sink
    int  hold_left;
    bit  hold_used;
    hold_left      = 0;
    hold_used      = 1'b0;
    cell_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        cell_bus.ready <= 1'b0;
      end else begin
        if (hold_go && !hold_used) begin
          hold_used = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
          hold_left--;
          cell_bus.ready <= 1'b0;
        end else if (quiet) begin
          cell_bus.ready <= 1'b1;
        end else begin
          cell_bus.ready <= ($urandom_range(99) >= 16);
        end
      end
    end
  end

  initial begin : stimulus
    int p, k;
    rst                  = 1'b1;
    rect_bus.valid       = 1'b0;
    rect_bus.rect_left   = '0;
    rect_bus.rect_top    = '0;
    rect_bus.rect_right  = '0;
    rect_bus.rect_bottom = '0;
    rect_bus.is_ui       = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_GRID_COLS;
    cfg_bus.data         = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        settle_cells();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_data);
      end else begin
        send_rect(dir_tab[i].rect, dir_tab[i].outcome, dir_tab[i].one_cell);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle_cells();
      quiet = (p == 2);
      write_reg(REG_GRID_COLS, pick_dim());
      write_reg(REG_GRID_ROWS, pick_dim());
      write_reg(REG_CELL_WIDTH, pick_size());
      write_reg(REG_CELL_HEIGHT, pick_size());
      write_reg(REG_CAMERA_X, pick_camera());
      write_reg(REG_CAMERA_Y, pick_camera());
      // cell side stalls while requests keep coming
      if (p == 4) hold_go = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) send_rect(make_rect(), EXP_PREDICT, '0);
    end

    settle_cells();
    if (cell_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
